// ===== design/bgcd_pkg.sv =====
// Shared types and constants for the binary GCD core.
// No dependencies; used by bgcd_cell and binary_gcd_core.
package bgcd_pkg;

  // Operand width; the cell row has one cell per bit.
  localparam int unsigned DATA_WIDTH = 32;
  // Width of the count of common factors of two, which is at most DATA_WIDTH - 1.
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  // Operation broadcast to every cell in the row.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SHR_AB = 3'd2,
    OP_SHR_A  = 3'd3,
    OP_SHR_B  = 3'd4,
    OP_SUB    = 3'd5,
    OP_SHL_A  = 3'd6
  } op_e;

  // Control word shared by all cells.
  typedef struct packed {
    op_e  op;
    logic swap;
  } cell_ctrl_t;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CHK  = 7'b0000010,
    ST_TWOS = 7'b0000100,
    ST_ODDA = 7'b0001000,
    ST_LOOP = 7'b0010000,
    ST_SHL  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

endpackage

// ===== design/bgcd_cell.sv =====
// One bit slice of the GCD datapath: holds one bit of each operand.
// Depends on bgcd_pkg for the operation code and control struct.
module bgcd_cell (
  input  logic                clk_i,
  input  bgcd_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_a_i,
  input  logic                load_b_i,
  input  logic                a_up_i,
  input  logic                b_up_i,
  input  logic                a_dn_i,
  input  logic                bor_ba_i,
  input  logic                bor_ab_i,
  output logic                a_o,
  output logic                b_o,
  output logic                bor_ba_o,
  output logic                bor_ab_o
);

  logic a_q, a_d;
  logic b_q, b_d;
  logic diff_ba, diff_ab;

  // Ripple borrow for both b - a and a - b.
  assign diff_ba  = b_q ^ a_q ^ bor_ba_i;
  assign bor_ba_o = (~b_q & a_q) | (~(b_q ^ a_q) & bor_ba_i);
  assign diff_ab  = a_q ^ b_q ^ bor_ab_i;
  assign bor_ab_o = (~a_q & b_q) | (~(a_q ^ b_q) & bor_ab_i);

  // Next bit for the broadcast operation.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    case (ctrl_i.op)
      bgcd_pkg::OP_LOAD: begin
        a_d = load_a_i;
        b_d = load_b_i;
      end
      bgcd_pkg::OP_SHR_AB: begin
        a_d = a_up_i;
        b_d = b_up_i;
      end
      bgcd_pkg::OP_SHR_A: a_d = a_up_i;
      bgcd_pkg::OP_SHR_B: b_d = b_up_i;
      bgcd_pkg::OP_SUB: begin
        if (ctrl_i.swap) begin
          a_d = b_q;
          b_d = diff_ab;
        end else begin
          b_d = diff_ba;
        end
      end
      bgcd_pkg::OP_SHL_A: a_d = a_dn_i;
      default: begin
        a_d = a_q;
        b_d = b_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

// ===== design/binary_gcd_core.sv =====
// Binary (Stein) GCD core: a row of bit cells driven by a small sequencer.
// Depends on bgcd_pkg and bgcd_cell.
//
// Usage: an operand pair is one transaction on the input channel
// (in_valid_i / in_ready_o with operand_a_i, operand_b_i); the gcd is one
// transaction on the output channel (out_valid_o / out_ready_i, gcd_value_o).
// One pair is worked at a time; in_ready_o is high only while the sequencer
// is idle. Each cycle applies at most one load, shift or compare-and-subtract across
// the whole row, with the borrow rippling through the cells.
// The time from the accepting edge to out_valid_o is data dependent: it is
// shortest when an operand is zero and otherwise grows with the shift and
// subtract steps and the common twos. The sequencer passes through idle
// before the next pair is taken, so pairs never overlap in the row.
// The iteration counts of the shift and shift/subtract loops set the rate.
// The result sits in an output register, so a new pair is taken as soon as
// the result is parked there, even while the receiver stalls; a second
// result waits in the row until the register frees up.
// Reset clears the sequencer and the output valid flag; operand bits are
// not reset.
module binary_gcd_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]      operand_a_i,
  input  logic [bgcd_pkg::DATA_WIDTH-1:0]      operand_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bgcd_pkg::DATA_WIDTH-1:0]      gcd_value_o
);

  localparam int unsigned W = bgcd_pkg::DATA_WIDTH;

  bgcd_pkg::state_e          state_q, state_d;
  logic [bgcd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       from_b_q, from_b_d;
  logic                       out_valid_q, out_valid_d;
  logic [W-1:0]               out_q, out_d;
  bgcd_pkg::cell_ctrl_t       ctrl;
  logic [W-1:0]               a_vec, b_vec;
  logic [W:0]                 bor_ba, bor_ab;
  logic                       a_zero, b_zero;

  // Row of cells; bit 0 is the least significant.
  assign bor_ba[0] = 1'b0;
  assign bor_ab[0] = 1'b0;
  for (genvar i = 0; i < W; i++) begin : g_cell
    bgcd_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .load_a_i (operand_a_i[i]),
      .load_b_i (operand_b_i[i]),
      .a_up_i   ((i == W - 1) ? 1'b0 : a_vec[(i + 1) % W]),
      .b_up_i   ((i == W - 1) ? 1'b0 : b_vec[(i + 1) % W]),
      .a_dn_i   ((i == 0) ? 1'b0 : a_vec[(i + W - 1) % W]),
      .bor_ba_i (bor_ba[i]),
      .bor_ab_i (bor_ab[i]),
      .a_o      (a_vec[i]),
      .b_o      (b_vec[i]),
      .bor_ba_o (bor_ba[i+1]),
      .bor_ab_o (bor_ab[i+1])
    );
  end

  assign a_zero = (a_vec == '0);
  assign b_zero = (b_vec == '0);

  // Sequencer: picks one row operation per cycle.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    from_b_d    = from_b_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    ctrl.op     = bgcd_pkg::OP_HOLD;
    ctrl.swap   = bor_ba[W];
    case (state_q)
      bgcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctrl.op = bgcd_pkg::OP_LOAD;
          cnt_d   = '0;
          state_d = bgcd_pkg::ST_CHK;
        end
      end
      bgcd_pkg::ST_CHK: begin
        from_b_d = a_zero;
        if (a_zero || b_zero) begin
          state_d = bgcd_pkg::ST_DONE;
        end else begin
          state_d = bgcd_pkg::ST_TWOS;
        end
      end
      bgcd_pkg::ST_TWOS: begin
        if (!(a_vec[0] | b_vec[0])) begin
          ctrl.op = bgcd_pkg::OP_SHR_AB;
          cnt_d   = cnt_q + 1'b1;
        end else begin
          state_d = bgcd_pkg::ST_ODDA;
        end
      end
      bgcd_pkg::ST_ODDA: begin
        if (!a_vec[0]) begin
          ctrl.op = bgcd_pkg::OP_SHR_A;
        end else begin
          state_d = bgcd_pkg::ST_LOOP;
        end
      end
      bgcd_pkg::ST_LOOP: begin
        if (b_zero) begin
          state_d = bgcd_pkg::ST_SHL;
        end else if (!b_vec[0]) begin
          ctrl.op = bgcd_pkg::OP_SHR_B;
        end else begin
          ctrl.op = bgcd_pkg::OP_SUB;
        end
      end
      bgcd_pkg::ST_SHL: begin
        if (cnt_q != '0) begin
          ctrl.op = bgcd_pkg::OP_SHL_A;
          cnt_d   = cnt_q - 1'b1;
        end else begin
          state_d = bgcd_pkg::ST_DONE;
        end
      end
      bgcd_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = from_b_q ? b_vec : a_vec;
          state_d     = bgcd_pkg::ST_IDLE;
        end
      end
      default: state_d = bgcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgcd_pkg::ST_IDLE;
      cnt_q       <= '0;
      from_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      from_b_q    <= from_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == bgcd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign gcd_value_o = out_q;

  // The first operand stays odd throughout the subtract loop.
  a_odd_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgcd_pkg::ST_LOOP) |-> a_vec[0])
    else $error("operand a even inside subtract loop");

  // A swapping subtract moves the old b into a.
  swap_moves_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == bgcd_pkg::OP_SUB && ctrl.swap) |=> (a_vec == $past(b_vec)))
    else $error("swap did not move b into a");

  // The common-twos count never reaches the word width.
  cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgcd_pkg::ST_TWOS) |-> (32'(cnt_q) < W))
    else $error("common twos count overflow");

  // A subtract is only issued with both operands odd.
  sub_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == bgcd_pkg::OP_SUB) |-> (a_vec[0] && b_vec[0]))
    else $error("subtract issued on an even operand");

endmodule

// ===== verif/binary_gcd_core_tb.sv =====
// Self-checking testbench for the binary GCD core.
// Depends on bgcd_pkg and binary_gcd_core; a scoreboard class predicts each gcd.
`timescale 1ns / 100ps

module binary_gcd_core_tb;

  localparam int unsigned W = bgcd_pkg::DATA_WIDTH;
  localparam int unsigned N_RAND = 1100;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef logic [W-1:0] word_t;

  // Holds the gcd values still owed by the core, oldest first.
  class gcd_scoreboard;
    word_t pending_gcds[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Stein's algorithm on the block's own word width.
    function word_t stein(word_t a, word_t b);
      int unsigned twos;
      word_t t;
      twos = 0;
      if (a == '0) return b;
      if (b == '0) return a;
      while (((a | b) & 1) == 0) begin
        a = a >> 1;
        b = b >> 1;
        twos++;
      end
      while (a[0] == 1'b0) a = a >> 1;
      do begin
        while (b[0] == 1'b0) b = b >> 1;
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        b = b - a;
      end while (b != '0);
      return a << twos;
    endfunction

    function void note_operands(word_t a, word_t b);
      pending_gcds.push_back(stein(a, b));
    endfunction

    function void check_gcd(word_t got);
      word_t want;
      if (pending_gcds.size() == 0) begin
        $display("%0t: unexpected gcd transaction, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_gcds.pop_front();
      if (got !== want) begin
        $display("%0t: gcd_value mismatch, expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  word_t operand_a_i = '0;
  word_t operand_b_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  word_t gcd_value_o;

  gcd_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit stim_done = 1'b0;
  longint unsigned cycles = 0;

  binary_gcd_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .gcd_value_o(gcd_value_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on a cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("binary_gcd_core_tb NOT OK");
      $finish;
    end
  end

  // Accepted transactions on both channels feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_operands(operand_a_i, operand_b_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_gcd(gcd_value_o);
  end

  function automatic word_t rand_word();
    word_t w;
    w = word_t'($urandom);
    return w;
  endfunction

  // Operands scaled by a shared random power of two with random cofactors, or raw or shifted noise.
  function automatic word_t shaped_word(int unsigned sel, int unsigned twos);
    word_t w;
    case (sel)
      0: w = rand_word();
      1: w = rand_word() >> $urandom_range(W - 1, 0);
      2: w = (rand_word() >> $urandom_range(W - 1, W / 2)) << twos;
      default: w = word_t'($urandom_range(255, 0)) << twos;
    endcase
    return w;
  endfunction

  // Offers one operand pair and holds it until accepted; valid drops only
  // for an idle gap or at the end of the stimulus.
  task automatic send_pair(word_t a, word_t b);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(3, 0) == 0) begin
      gap = $urandom_range(9, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operand_a_i <= a;
    operand_b_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: random stall bursts, one long hold-off early on.
  initial begin : receiver
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    out_ready_i <= 1'b0;
    repeat (2000) @(posedge clk_i);
    forever begin
      if (quiet_phase) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'($urandom_range(1, 0));
        n = $urandom_range(9, 1);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    word_t dir_a[$];
    word_t dir_b[$];
    word_t ones;
    word_t msb;
    int unsigned twos;
    int unsigned tail;
    ones = '1;
    msb = word_t'(1) << (W - 1);
    dir_a = '{0, 0, 5, ones, 0, msb, msb, ones, 1, 48, 12, 17, 1024,
              ones, 'h5555_5555, 'hFFFF_FFFE, 6, 1, msb, 'h8000_0001};
    dir_b = '{0, 7, 0, 0, ones, msb, 1, ones, 1, 18, 12, 13, 4096,
              'hFFFF_FFFE, 'hAAAA_AAAA, 'h7FFF_FFFF, 9, ones, 'h4000_0000, 3};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero operands, extremes, equal and coprime pairs.
    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);

    // Random pairs; the last part runs without idling.
    tail = N_RAND - 150;
    for (int unsigned i = 0; i < N_RAND; i++) begin
      if (i == tail) quiet_phase = 1'b1;
      twos = $urandom_range(W - 1, 0);
      if ($urandom_range(19, 0) == 0)
        send_pair($urandom_range(1, 0) ? '0 : rand_word(), '0);
      else
        send_pair(shaped_word($urandom_range(3, 0), twos),
                  shaped_word($urandom_range(3, 0), twos));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain the scoreboard, wait a further margin, then report.
  initial begin : finisher
    wait (stim_done);
    while (sb.pending_gcds.size() != 0) @(posedge clk_i);
    repeat (3 * W + 20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("binary_gcd_core_tb OK");
    end else begin
      $display("binary_gcd_core_tb NOT OK");
    end
    $finish;
  end

endmodule
